// ----- rtl/core/ipps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipps_pkg: shared types and constants of the sensor packet parser
// Holds the header characters, register codes, field widths and the
// command and status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package ipps_pkg;

    localparam int MAX_WORDS = 15;
    localparam int IDX_W     = 4;
    localparam int LEN_W     = 6;
    localparam int SUM_W     = 16;

    localparam logic [7:0] HDR_S = 8'h73;
    localparam logic [7:0] HDR_N = 8'h6E;
    localparam logic [7:0] HDR_P = 8'h70;

    localparam logic [SUM_W-1:0] HDR_SUM = SUM_W'(16'h0073 + 16'h006E + 16'h0070);

    localparam logic [7:0] ADDR_ACCEL = 8'h65;
    localparam logic [7:0] ADDR_GYRO  = 8'h61;
    localparam logic [7:0] ADDR_QUAT  = 8'h6D;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_ACCEL = 2'd1;
    localparam logic [1:0] KIND_GYRO  = 2'd2;
    localparam logic [1:0] KIND_QUAT  = 2'd3;

    // Commands from the controller; each is already qualified by the handshake.
    typedef struct packed {
        logic init_sum;
        logic ld_type;
        logic ld_addr;
        logic ld_data;
        logic ld_chk_hi;
        logic clr_emit;
        logic ld_single;
        logic ld_word;
    } cmd_t;

    // Status from the datapath.
    typedef struct packed {
        logic is_s;
        logic is_n;
        logic is_p;
        logic len_zero;
        logic data_done;
        logic sum_match;
        logic words_zero;
        logic word_last;
        logic out_free;
    } sts_t;

    function automatic logic [1:0] kind_of(input logic [7:0] addr);
        logic [1:0] k;
        begin
            k = KIND_OTHER;
            if (addr == ADDR_ACCEL)
            begin
                k = KIND_ACCEL;
            end
            else if (addr == ADDR_GYRO)
            begin
                k = KIND_GYRO;
            end
            else if (addr == ADDR_QUAT)
            begin
                k = KIND_QUAT;
            end
            return k;
        end
    endfunction

endpackage

// ----- rtl/core/ipps_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipps_dp: packet parser datapath
// Captures type and address, sums the packet, assembles payload words into
// a small store and holds the result register of the output channel.
// ----------------------------------------------------------------------------
module ipps_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         rx_byte,
    input  ipps_pkg::cmd_t     cmd,
    output ipps_pkg::sts_t     sts,
    input  logic               res_stall,
    output logic               res_valid,
    output logic               packet_ok,
    output logic [7:0]         reg_address,
    output logic [7:0]         type_byte,
    output logic               word_valid,
    output logic [3:0]         word_index,
    output logic [31:0]        data_word,
    output logic [1:0]         reg_kind,
    output logic               last
);
    import ipps_pkg::*;

    logic [7:0]       type_reg;
    logic [7:0]       addr_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] cnt_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [7:0]       chk_hi_reg;
    logic [23:0]      acc_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [31:0]      payload_mem [0:MAX_WORDS-1];

    logic             res_valid_reg;
    logic             ok_reg;
    logic [7:0]       res_addr_reg;
    logic [7:0]       res_type_reg;
    logic             wvalid_reg;
    logic [IDX_W-1:0] windex_reg;
    logic [31:0]      word_reg;
    logic             last_reg;

    logic [IDX_W-1:0] words;
    logic [IDX_W-1:0] wr_idx;
    logic [LEN_W:0]   cnt_inc;
    logic [LEN_W-1:0] len_next;

    assign words   = len_reg[LEN_W-1:2];
    assign wr_idx  = cnt_reg[LEN_W-1:2];
    assign cnt_inc = {1'b0, cnt_reg} + {{LEN_W{1'b0}}, 1'b1};

    always_comb
    begin
        if (rx_byte[7])
        begin
            len_next = rx_byte[6] ? {rx_byte[5:2], 2'b00} : LEN_W'(4);
        end
        else
        begin
            len_next = '0;
        end
    end

    always_comb
    begin
        sts.is_s       = (rx_byte == HDR_S);
        sts.is_n       = (rx_byte == HDR_N);
        sts.is_p       = (rx_byte == HDR_P);
        sts.len_zero   = (len_reg == '0);
        sts.data_done  = (cnt_inc >= {1'b0, len_reg});
        sts.sum_match  = ({chk_hi_reg, rx_byte} == sum_reg);
        sts.words_zero = (words == '0);
        sts.word_last  = (idx_reg == (words - IDX_W'(1)));
        sts.out_free   = !res_valid_reg || !res_stall;
    end

    // Parse registers and running sum.
    always_ff @(posedge clk)
    begin
        if (cmd.init_sum)
        begin
            sum_reg <= HDR_SUM;
        end
        else if (cmd.ld_type || cmd.ld_addr || cmd.ld_data)
        begin
            sum_reg <= sum_reg + {8'h00, rx_byte};
        end

        if (cmd.ld_type)
        begin
            type_reg <= rx_byte;
            len_reg  <= len_next;
        end

        if (cmd.ld_addr)
        begin
            addr_reg <= rx_byte;
            cnt_reg  <= '0;
        end
        else if (cmd.ld_data)
        begin
            cnt_reg <= cnt_inc[LEN_W-1:0];
            acc_reg <= {acc_reg[15:0], rx_byte};
        end

        if (cmd.ld_chk_hi)
        begin
            chk_hi_reg <= rx_byte;
        end

        if (cmd.clr_emit)
        begin
            idx_reg <= '0;
        end
        else if (cmd.ld_word)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // A word is written once, on its fourth byte.
    always_ff @(posedge clk)
    begin
        if (cmd.ld_data && (cnt_reg[1:0] == 2'b11) && (wr_idx < IDX_W'(MAX_WORDS)))
        begin
            payload_mem[wr_idx] <= {acc_reg, rx_byte};
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.ld_single || cmd.ld_word)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Address and type are copied so that the next packet can be parsed
    // while a result still waits.
    always_ff @(posedge clk)
    begin
        if (cmd.ld_single)
        begin
            ok_reg       <= sts.sum_match;
            res_addr_reg <= addr_reg;
            res_type_reg <= type_reg;
            wvalid_reg   <= 1'b0;
            windex_reg   <= '0;
            word_reg     <= '0;
            last_reg     <= 1'b1;
        end
        else if (cmd.ld_word)
        begin
            ok_reg       <= 1'b1;
            res_addr_reg <= addr_reg;
            res_type_reg <= type_reg;
            wvalid_reg   <= 1'b1;
            windex_reg   <= idx_reg;
            word_reg     <= payload_mem[idx_reg];
            last_reg     <= sts.word_last;
        end
    end

    assign res_valid   = res_valid_reg;
    assign packet_ok   = ok_reg;
    assign reg_address = res_addr_reg;
    assign type_byte   = res_type_reg;
    assign word_valid  = wvalid_reg;
    assign word_index  = windex_reg;
    assign data_word   = word_reg;
    assign reg_kind    = kind_of(res_addr_reg);
    assign last        = last_reg;

endmodule

// ----- rtl/core/ipps_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipps_ctrl: packet parser controller
// Walks the packet format byte by byte and sequences the emission of the
// stored payload words into the result register.
// ----------------------------------------------------------------------------
module ipps_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rx_valid,
    output logic           rx_stall,
    input  ipps_pkg::sts_t sts,
    output ipps_pkg::cmd_t cmd
);
    import ipps_pkg::*;

    typedef enum logic [3:0] {
        ST_WAIT_S,
        ST_WAIT_N,
        ST_WAIT_P,
        ST_TYPE,
        ST_ADDR,
        ST_DATA,
        ST_CHK_HI,
        ST_CHK_LO,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take;

    // The last checksum byte must wait until the result register can load.
    assign rx_stall = (state_reg == ST_EMIT) || ((state_reg == ST_CHK_LO) && !sts.out_free);
    assign take     = rx_valid && !rx_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_WAIT_S:
            begin
                if (take)
                begin
                    state_next = sts.is_s ? ST_WAIT_N : ST_WAIT_S;
                end
            end
            ST_WAIT_N:
            begin
                if (take)
                begin
                    state_next = sts.is_n ? ST_WAIT_P : ST_WAIT_S;
                end
            end
            ST_WAIT_P:
            begin
                if (take)
                begin
                    cmd.init_sum = sts.is_p;
                    state_next   = sts.is_p ? ST_TYPE : ST_WAIT_S;
                end
            end
            ST_TYPE:
            begin
                if (take)
                begin
                    cmd.ld_type = 1'b1;
                    state_next  = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                if (take)
                begin
                    cmd.ld_addr = 1'b1;
                    state_next  = sts.len_zero ? ST_CHK_HI : ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (take)
                begin
                    cmd.ld_data = 1'b1;
                    if (sts.data_done)
                    begin
                        state_next = ST_CHK_HI;
                    end
                end
            end
            ST_CHK_HI:
            begin
                if (take)
                begin
                    cmd.ld_chk_hi = 1'b1;
                    state_next    = ST_CHK_LO;
                end
            end
            ST_CHK_LO:
            begin
                if (take)
                begin
                    if (!sts.sum_match || sts.words_zero)
                    begin
                        cmd.ld_single = 1'b1;
                        state_next    = ST_WAIT_S;
                    end
                    else
                    begin
                        cmd.clr_emit = 1'b1;
                        state_next   = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.ld_word = 1'b1;
                    if (sts.word_last)
                    begin
                        state_next = ST_WAIT_S;
                    end
                end
            end
            default:
            begin
                state_next = ST_WAIT_S;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT_S;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/imu_packet_parser_sum16.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_packet_parser_sum16: sensor link packet parser with 16-bit sum check
//
//   channel | direction | handshake            | payload
//   rx      | in        | rx_valid / rx_stall  | rx_byte
//   res     | out       | res_valid / res_stall| packet_ok .. last
//
// Each byte takes one cycle while a packet is being parsed, but a stalled
// result register holds the emission and, at the last checksum byte, the
// input. When the last checksum byte is taken, a good packet with N words
// holds off input while the controller moves the stored words into the
// result register; a bad or empty packet gives its single result at once.
// Reset clears the controller and the result valid flag.
// ----------------------------------------------------------------------------
module imu_packet_parser_sum16 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        packet_ok,
    output logic [7:0]  reg_address,
    output logic [7:0]  type_byte,
    output logic        word_valid,
    output logic [3:0]  word_index,
    output logic [31:0] data_word,
    output logic [1:0]  reg_kind,
    output logic        last
);
    import ipps_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ipps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ipps_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx_byte),
        .cmd         (cmd),
        .sts         (sts),
        .res_stall   (res_stall),
        .res_valid   (res_valid),
        .packet_ok   (packet_ok),
        .reg_address (reg_address),
        .type_byte   (type_byte),
        .word_valid  (word_valid),
        .word_index  (word_index),
        .data_word   (data_word),
        .reg_kind    (reg_kind),
        .last        (last)
    );

endmodule

// ----- tb/imu_packet_parser_sum16_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_packet_parser_sum16_tb: self-checking bench for the sensor packet parser
// A short directed set of packets comes first. It covers empty packets,
// single words, batches, bad checksums and broken headers. Random packets
// follow, mixed with noise and cut-off packets. Input gaps and result stalls
// are random. Every result is predicted from the accepted byte stream and is
// compared field by field with what the parser emits.
// ----------------------------------------------------------------------------
module imu_packet_parser_sum16_tb;
    import ipps_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MIN_BYTES    = 200;

    typedef enum logic [2:0] {
        WAIT_S,
        WAIT_N,
        WAIT_P,
        GET_TYPE,
        GET_ADDR,
        GET_DATA,
        GET_SUM_HI,
        GET_SUM_LO
    } link_phase_t;

    typedef struct {
        logic        packet_ok;
        logic [7:0]  reg_address;
        logic [7:0]  type_byte;
        logic        word_valid;
        logic [3:0]  word_index;
        logic [31:0] data_word;
        logic [1:0]  reg_kind;
        logic        last;
    } parse_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        rx_valid  = 1'b0;
    logic        rx_stall;
    logic [7:0]  rx_byte   = 8'h00;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic        packet_ok;
    logic [7:0]  reg_address;
    logic [7:0]  type_byte;
    logic        word_valid;
    logic [3:0]  word_index;
    logic [31:0] data_word;
    logic [1:0]  reg_kind;
    logic        last;

    // Parser state as the bench predicts it.
    link_phase_t phase = WAIT_S;
    logic [7:0]  pkt_type   = 8'h00;
    logic [7:0]  pkt_addr   = 8'h00;
    logic [5:0]  pkt_len    = 6'd0;
    logic [5:0]  data_count = 6'd0;
    logic [15:0] sum_acc    = 16'h0000;
    logic [7:0]  sum_hi     = 8'h00;
    logic [31:0] word_buf [MAX_WORDS];

    parse_result_t pending_results [$];
    logic [7:0]    link_bytes [$];

    int bytes_sent      = 0;
    int bytes_taken     = 0;
    int quiet_cycles    = 0;
    int mismatches      = 0;
    bit calm            = 1'b0;
    bit moved           = 1'b0;

    imu_packet_parser_sum16 uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .rx_byte     (rx_byte),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .packet_ok   (packet_ok),
        .reg_address (reg_address),
        .type_byte   (type_byte),
        .word_valid  (word_valid),
        .word_index  (word_index),
        .data_word   (data_word),
        .reg_kind    (reg_kind),
        .last        (last)
    );

    always #2 clk = ~clk;

    function automatic logic [5:0] payload_bytes(input logic [7:0] ptype);
        logic [5:0] n;
        n = 6'd0;
        if (ptype[7])
        begin
            if (ptype[6])
                n = {ptype[5:2], 2'b00};
            else
                n = 6'd4;
        end
        return n;
    endfunction

    function automatic void expect_result(input logic ok, input logic has_word,
                                          input logic [3:0] index,
                                          input logic [31:0] word, input logic fin);
        parse_result_t r;
        r.packet_ok   = ok;
        r.reg_address = pkt_addr;
        r.type_byte   = pkt_type;
        r.word_valid  = has_word;
        r.word_index  = index;
        r.data_word   = word;
        r.last        = fin;
        case (pkt_addr)
            ADDR_ACCEL: r.reg_kind = KIND_ACCEL;
            ADDR_GYRO:  r.reg_kind = KIND_GYRO;
            ADDR_QUAT:  r.reg_kind = KIND_QUAT;
            default:    r.reg_kind = KIND_OTHER;
        endcase
        pending_results.push_back(r);
    endfunction

    function automatic void parse_link_byte(input logic [7:0] b);
        logic [3:0] w;
        int words;
        int i;
        w = data_count[5:2];
        words = int'(pkt_len >> 2);
        case (phase)
            WAIT_S:
            begin
                if (b == HDR_S)
                    phase = WAIT_N;
                else
                    phase = WAIT_S;
            end
            WAIT_N:
            begin
                if (b == HDR_N)
                    phase = WAIT_P;
                else
                    phase = WAIT_S;
            end
            WAIT_P:
            begin
                if (b == HDR_P)
                begin
                    phase = GET_TYPE;
                    sum_acc = HDR_SUM;
                end
                else
                begin
                    phase = WAIT_S;
                end
            end
            GET_TYPE:
            begin
                pkt_type = b;
                sum_acc += {8'h00, b};
                pkt_len = payload_bytes(b);
                phase = GET_ADDR;
            end
            GET_ADDR:
            begin
                pkt_addr = b;
                sum_acc += {8'h00, b};
                data_count = 6'd0;
                if (pkt_len == 6'd0)
                    phase = GET_SUM_HI;
                else
                    phase = GET_DATA;
            end
            GET_DATA:
            begin
                sum_acc += {8'h00, b};
                if (w < MAX_WORDS)
                begin
                    if (data_count[1:0] == 2'd0)
                        word_buf[w] = {24'd0, b};
                    else
                        word_buf[w] = {word_buf[w][23:0], b};
                end
                data_count++;
                if (data_count >= pkt_len)
                    phase = GET_SUM_HI;
            end
            GET_SUM_HI:
            begin
                sum_hi = b;
                phase = GET_SUM_LO;
            end
            default:
            begin
                phase = WAIT_S;
                if (words > MAX_WORDS)
                    words = MAX_WORDS;
                // A bad sum and an empty packet each give a single result
                // that carries no word.
                if ({sum_hi, b} != sum_acc)
                    expect_result(1'b0, 1'b0, 4'd0, 32'd0, 1'b1);
                else if (words == 0)
                    expect_result(1'b1, 1'b0, 4'd0, 32'd0, 1'b1);
                else
                begin
                    for (i = 0; i < words; i++)
                        expect_result(1'b1, 1'b1, 4'(i), word_buf[i], i == words - 1);
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic compare_result(input parse_result_t want);
        if (packet_ok !== want.packet_ok)
            report_mismatch($sformatf("packet_ok got %0h expected %0h",
                                      packet_ok, want.packet_ok));
        if (reg_address !== want.reg_address)
            report_mismatch($sformatf("reg_address got %0h expected %0h",
                                      reg_address, want.reg_address));
        if (type_byte !== want.type_byte)
            report_mismatch($sformatf("type_byte got %0h expected %0h",
                                      type_byte, want.type_byte));
        if (word_valid !== want.word_valid)
            report_mismatch($sformatf("word_valid got %0h expected %0h",
                                      word_valid, want.word_valid));
        if (word_index !== want.word_index)
            report_mismatch($sformatf("word_index got %0h expected %0h",
                                      word_index, want.word_index));
        if (data_word !== want.data_word)
            report_mismatch($sformatf("data_word got %0h expected %0h",
                                      data_word, want.data_word));
        if (reg_kind !== want.reg_kind)
            report_mismatch($sformatf("reg_kind got %0h expected %0h",
                                      reg_kind, want.reg_kind));
        if (last !== want.last)
            report_mismatch($sformatf("last got %0h expected %0h", last, want.last));
    endtask

    // Queues one framed packet; fill below zero means random data bytes.
    task automatic add_packet(input logic [7:0] ptype, input logic [7:0] paddr,
                              input bit bad_sum, input int fill);
        logic [15:0] sum;
        logic [7:0] d;
        int n;
        int k;
        sum = HDR_SUM + {8'h00, ptype} + {8'h00, paddr};
        n = int'(payload_bytes(ptype));
        link_bytes.push_back(HDR_S);
        link_bytes.push_back(HDR_N);
        link_bytes.push_back(HDR_P);
        link_bytes.push_back(ptype);
        link_bytes.push_back(paddr);
        for (k = 0; k < n; k++)
        begin
            if (fill < 0)
                d = 8'($urandom);
            else
                d = 8'(fill);
            sum += {8'h00, d};
            link_bytes.push_back(d);
        end
        if (bad_sum)
            sum += 16'($urandom_range(1, 16'hFFFF));
        link_bytes.push_back(sum[15:8]);
        link_bytes.push_back(sum[7:0]);
    endtask

    // Noise leans on header characters so that false starts are common.
    task automatic add_noise(input int count);
        int k;
        for (k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 5))
                0: link_bytes.push_back(HDR_S);
                1: link_bytes.push_back(HDR_N);
                2: link_bytes.push_back(HDR_P);
                default: link_bytes.push_back(8'($urandom));
            endcase
        end
    endtask

    // Driver: a new byte or a new stall decision at each falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rx_valid <= 1'b0;
            res_stall <= 1'b0;
        end
        else
        begin
            calm = (bytes_sent >= 80 && bytes_sent < 140);
            if (!(rx_valid && bytes_taken != bytes_sent))
            begin
                if (link_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= 10))
                begin
                    rx_byte <= link_bytes.pop_front();
                    rx_valid <= 1'b1;
                    bytes_sent++;
                end
                else
                begin
                    rx_valid <= 1'b0;
                end
            end
            res_stall <= !calm && ($urandom_range(0, 99) < 10);
        end
    end

    // Monitor: checks results and feeds accepted bytes to the prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (res_valid && !res_stall)
            begin
                moved = 1'b1;
                if (pending_results.size() == 0)
                    report_mismatch("result arrived with nothing expected");
                else
                    compare_result(pending_results.pop_front());
            end
            if (rx_valid && !rx_stall)
            begin
                moved = 1'b1;
                parse_link_byte(rx_byte);
                bytes_taken++;
            end
            if (moved)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge clk);
        $display("** imu_packet_parser_sum16: FAILED **");
        $finish;
    end

    initial
    begin
        logic [7:0] ptype;
        logic [7:0] paddr;
        int k;

        // Broken headers, including a repeated first character.
        link_bytes.push_back(HDR_S);
        link_bytes.push_back(HDR_N);
        link_bytes.push_back(8'h78);
        link_bytes.push_back(HDR_S);
        link_bytes.push_back(HDR_S);
        link_bytes.push_back(HDR_N);
        link_bytes.push_back(HDR_P);
        add_packet(8'h00, ADDR_ACCEL, 1'b0, 0);
        add_packet(8'h7F, 8'hFF, 1'b0, -1);
        add_packet(8'hBC, ADDR_GYRO, 1'b0, -1);
        add_packet(8'hC0, ADDR_QUAT, 1'b0, -1);
        add_packet(8'hC4, 8'h00, 1'b0, 8'h00);
        add_packet(8'hFC, ADDR_QUAT, 1'b0, 8'hFF);
        add_packet(8'hD7, 8'h80, 1'b0, -1);
        add_packet(8'h80, ADDR_ACCEL, 1'b1, -1);
        add_packet(8'hC8, ADDR_GYRO, 1'b1, -1);
        add_packet(8'h00, 8'h12, 1'b1, 0);

        while (link_bytes.size() < MIN_BYTES)
        begin
            k = $urandom_range(0, 99);
            if (k < 10)
            begin
                add_noise($urandom_range(1, 6));
            end
            else if (k < 15)
            begin
                // A packet cut short; what follows is read as its remainder.
                link_bytes.push_back(HDR_S);
                link_bytes.push_back(HDR_N);
                link_bytes.push_back(HDR_P);
                add_noise($urandom_range(1, 3));
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: ptype = 8'($urandom);
                    1, 2: ptype = {1'b0, 7'($urandom)};
                    3, 4: ptype = {2'b10, 6'($urandom)};
                    9: ptype = {2'b11, 4'($urandom_range(5, 15)), 2'($urandom)};
                    default: ptype = {2'b11, 4'($urandom_range(0, 4)), 2'($urandom)};
                endcase
                case ($urandom_range(0, 3))
                    0: paddr = ADDR_ACCEL;
                    1: paddr = ADDR_GYRO;
                    2: paddr = ADDR_QUAT;
                    default: paddr = 8'($urandom);
                endcase
                add_packet(ptype, paddr, $urandom_range(0, 99) < 15, -1);
            end
        end

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        while (link_bytes.size() != 0 || bytes_taken != bytes_sent ||
               pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("** imu_packet_parser_sum16: PASSED **");
        else
            $display("** imu_packet_parser_sum16: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/ipps_pkg.sv
rtl/core/ipps_dp.sv
rtl/core/ipps_ctrl.sv
rtl/core/imu_packet_parser_sum16.sv
tb/imu_packet_parser_sum16_tb.sv
